@@ rtl/lst_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU slice tracker package
// Shared sizes and the command and status bundles between the controller and
// the datapath of the recency list.
// ----------------------------------------------------------------------------
package lst_pkg;

    // Number of slice numbers the list can hold.
    localparam int CAPACITY   = 16;
    // Width of one slice number.
    localparam int SLICE_BITS = 12;
    // Width of the max_kept register.
    localparam int MAX_KEPT_W = 5;
    // Counter width: holds CAPACITY + 1 (the list plus one appended entry).
    localparam int CNT_W      = $clog2(CAPACITY + 2);
    // Slots in the list register file, including the transient extra slot.
    localparam int SLOTS      = CAPACITY + 1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the requested slice number
        logic update;  // remove an earlier copy and append at the newest end
        logic evict;   // pop the oldest entry into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic over_limit;  // the list holds more entries than the limit
        logic out_free;    // the output register can take a result this cycle
    } t_dp_status;

endpackage

@@ rtl/lst_touch_if.sv @@
// ----------------------------------------------------------------------------
// Touch channel
// Carries one slice number per request from the source to the tracker.
// ----------------------------------------------------------------------------
interface lst_touch_if
    import lst_pkg::*;
    ();

    logic                  valid;
    logic                  ready;
    logic [SLICE_BITS-1:0] slice_number;

    modport source (output valid, output slice_number, input ready);
    modport sink   (input valid, input slice_number, output ready);

endinterface

@@ rtl/lst_evict_if.sv @@
// ----------------------------------------------------------------------------
// Eviction channel
// Carries one evicted slice number per request, with a last-of-run mark.
// ----------------------------------------------------------------------------
interface lst_evict_if
    import lst_pkg::*;
    ();

    logic                  valid;
    logic                  ready;
    logic [SLICE_BITS-1:0] evicted_slice;
    logic                  last;

    modport source (output valid, output evicted_slice, output last, input ready);
    modport sink   (input valid, input evicted_slice, input last, output ready);

endinterface

@@ rtl/lst_datapath.sv @@
// ----------------------------------------------------------------------------
// LRU slice tracker datapath
// Holds the recency list, the entry count, the limit register and the
// output register. Performs the parallel match, compaction and append together
// on one update command and pops one oldest entry per eviction command.
// ----------------------------------------------------------------------------
module lst_datapath
    import lst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [MAX_KEPT_W-1:0] i_cfg_wdata,
    input  logic [SLICE_BITS-1:0] i_slice_number,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    lst_evict_if.source           o_evict
);

    logic [SLICE_BITS-1:0] r_list [SLOTS];
    logic [SLICE_BITS-1:0] n_list [SLOTS];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [MAX_KEPT_W-1:0] r_max_kept;
    logic [SLICE_BITS-1:0] r_slice;
    logic                  r_out_valid;
    logic [SLICE_BITS-1:0] r_out_slice;
    logic                  r_out_last;

    logic [CNT_W-1:0]      limit;
    logic [CAPACITY-1:0]   hit;
    logic                  any_hit;
    logic [CNT_W-1:0]      append_idx;
    logic                  out_free;

    // Effective limit: zero acts as one, anything above capacity as capacity.
    always_comb begin
        if (r_max_kept == '0) begin
            limit = CNT_W'(1);
        end else if (int'(r_max_kept) > CAPACITY) begin
            limit = CNT_W'(CAPACITY);
        end else begin
            limit = CNT_W'(r_max_kept);
        end
    end

    // Parallel match of the captured slice against the valid entries.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            hit[i] = (CNT_W'(i) < r_count) && (r_list[i] == r_slice);
        end
    end

    assign any_hit    = |hit;
    assign append_idx = r_count - CNT_W'(any_hit);
    assign out_free   = !r_out_valid || o_evict.ready;

    assign o_status.over_limit = (r_count > limit);
    assign o_status.out_free   = out_free;

    // Next list contents: compaction plus append, or a pop of the oldest entry.
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            n_list[i] = r_list[i];
        end
        n_count = r_count;
        if (i_cmd.update) begin
            // Entries at and above the matching slot move down by one.
            for (int i = 0; i < CAPACITY; i++) begin
                seen = seen | hit[i];
                if (seen) begin
                    n_list[i] = r_list[i + 1];
                end
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (CNT_W'(i) == append_idx) begin
                    n_list[i] = r_slice;
                end
            end
            n_count = append_idx + CNT_W'(1);
        end else if (i_cmd.evict) begin
            for (int i = 0; i < CAPACITY; i++) begin
                n_list[i] = r_list[i + 1];
            end
            n_count = r_count - CNT_W'(1);
        end
    end

    // List storage, no reset: entries at or beyond the count are never read.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            r_list[i] <= n_list[i];
        end
        if (i_cmd.load) begin
            r_slice <= i_slice_number;
        end
        if (i_cmd.evict) begin
            r_out_slice <= r_list[0];
            r_out_last  <= (r_count == limit + CNT_W'(1));
        end
    end

    // Control state: count, limit register and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_max_kept  <= MAX_KEPT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                r_max_kept <= i_cfg_wdata;
            end
            if (i_cmd.evict) begin
                r_out_valid <= 1'b1;
            end else if (o_evict.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_evict.valid         = r_out_valid;
    assign o_evict.evicted_slice = r_out_slice;
    assign o_evict.last          = r_out_last;

endmodule

@@ rtl/lst_controller.sv @@
// ----------------------------------------------------------------------------
// LRU slice tracker controller
// Sequences one touch: capture, list update, then one eviction per cycle
// while the list is over its limit and the output register is free.
// ----------------------------------------------------------------------------
module lst_controller
    import lst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_status  i_status,
    output t_dp_cmd     o_cmd,
    lst_touch_if.sink   i_touch
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_UPDATE = 3'b010,
        S_EVICT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    assign i_touch.ready = (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.update = 1'b0;
        o_cmd.evict  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_touch.valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_EVICT;
            end
            S_EVICT: begin
                if (!i_status.over_limit) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.evict = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/lru_slice_tracker.sv @@
// ----------------------------------------------------------------------------
// LRU slice tracker
// Recency list of slice numbers, oldest first; each touch moves the slice to
// the newest end and evicts the oldest entries above the max_kept limit.
// ----------------------------------------------------------------------------
// A touch is accepted in the idle state, which captures its slice number; the
// update state then does the parallel match, compaction and append, and the
// eviction state pops one entry per cycle into the output register while that
// register is free, and returns to idle once it sees the list within its limit.
// The next touch is accepted only after that return to idle.
// Synchronous active-low reset empties the list and sets max_kept to 1.
module lru_slice_tracker
    import lst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [MAX_KEPT_W-1:0] i_cfg_wdata,
    lst_touch_if.sink             i_touch,
    lst_evict_if.source           o_evict
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer for one touch at a time.
    lst_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd),
        .i_touch  (i_touch)
    );

    // List storage, match and output register.
    lst_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_slice_number (i_touch.slice_number),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_evict        (o_evict)
    );

    // At most one datapath command per cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.update, cmd.evict}))
        else $error("more than one datapath command in a cycle");

    // An eviction only happens into a free output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.evict |-> status.out_free)
        else $error("eviction would overwrite a pending result");

    // An eviction only happens while the list is above its limit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.evict |-> status.over_limit)
        else $error("eviction while the list is within its limit");

    // An eviction always presents a result in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.evict |=> o_evict.valid)
        else $error("eviction did not present a result");

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// LRU slice tracker testbench
// Sends slice-number touches to the tracker and checks every eviction against
// a recency list kept alongside it. Directed tests cover the default limit,
// limits above capacity and a limit lowered to zero. Random traffic then runs
// under several limits with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    import lst_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    // Cycles for a touch that evicts nothing to finish after the last result.
    localparam int SETTLE_GAP   = 8;
    localparam int PHASE_ITEMS  = 10;

    typedef logic [SLICE_BITS-1:0] t_slice;

    typedef struct packed {
        t_slice slice;
        logic   last;
    } t_eviction;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [MAX_KEPT_W-1:0] i_cfg_wdata;

    lst_touch_if touch_if();
    lst_evict_if evict_if();

    lru_slice_tracker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_touch     (touch_if),
        .o_evict     (evict_if)
    );

    // Mirror of the tracker state and the evictions still to arrive.
    t_slice              recency_list[$];
    logic [MAX_KEPT_W-1:0] kept_limit = MAX_KEPT_W'(1);
    t_eviction           evictions_due[$];
    t_slice              hot_slices[20];

    int idle_pct  = 0;
    int stall_pct = 0;
    int errors    = 0;
    int cycles    = 0;

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver side: stall at random according to stall_pct.
    always @(negedge i_clk) begin
        evict_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Move a touched slice to the newest end and queue the evictions it causes.
    function automatic void apply_touch(input t_slice s);
        t_slice    kept[$];
        int        lim;
        int        drop;
        t_eviction e;
        foreach (recency_list[i]) begin
            if (recency_list[i] != s) begin
                kept = {kept, recency_list[i]};
            end
        end
        kept = {kept, s};
        lim = int'(kept_limit);
        if (lim < 1) begin
            lim = 1;
        end
        if (lim > CAPACITY) begin
            lim = CAPACITY;
        end
        drop = (kept.size() > lim) ? kept.size() - lim : 0;
        for (int i = 0; i < drop; i++) begin
            e.slice = kept[0];
            kept.delete(0);
            e.last  = (i == drop - 1);
            evictions_due = {evictions_due, e};
        end
        recency_list = kept;
    endfunction

    // Compare each accepted eviction with the oldest one predicted.
    always @(posedge i_clk) begin : check_evictions
        t_eviction want;
        if (i_rst_n && evict_if.valid && evict_if.ready) begin
            if (evictions_due.size() == 0) begin
                $error("unexpected eviction of slice %0d", evict_if.evicted_slice);
                errors++;
            end else begin
                want = evictions_due[0];
                evictions_due.delete(0);
                if (evict_if.evicted_slice !== want.slice) begin
                    $error("evicted_slice: expected %0d, got %0d",
                           want.slice, evict_if.evicted_slice);
                    errors++;
                end
                if (evict_if.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, evict_if.last);
                    errors++;
                end
            end
        end
    end

    // Send one touch request; called and returning at a falling edge.
    task automatic send_touch(input t_slice s);
        while ($urandom_range(99) < idle_pct) begin
            touch_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        touch_if.valid        <= 1'b1;
        touch_if.slice_number <= s;
        @(posedge i_clk);
        while (!touch_if.ready) begin
            @(posedge i_clk);
        end
        apply_touch(s);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until the tracker has gone quiet.
    task automatic settle();
        touch_if.valid <= 1'b0;
        while (evictions_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_GAP) @(negedge i_clk);
    endtask

    // Write the max_kept register; only called while the tracker is idle.
    task automatic write_limit(input logic [MAX_KEPT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        kept_limit = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Limit of one after reset: each new slice pushes out the previous one,
    // and retouching the only entry evicts nothing. Slice zero is ordinary.
    task automatic test_default_limit();
        send_touch(12'hFFF);
        send_touch(12'h000);
        send_touch(12'h000);
        send_touch(12'hAAA);
        send_touch(12'h555);
    endtask

    // A limit above capacity acts as capacity: fill the list, retouch a
    // middle entry, then one more new slice evicts the oldest.
    task automatic test_limit_above_capacity();
        settle();
        write_limit(5'd31);
        for (int i = 0; i < CAPACITY - 1; i++) begin
            send_touch(t_slice'(i * 273 + 17));
        end
        send_touch(t_slice'(290));
        send_touch(12'hFFE);
    endtask

    // A limit of zero acts as one: the next touch drains the full list in one
    // run of evictions, oldest first, with last on the final one.
    task automatic test_lowered_limit();
        settle();
        write_limit(5'd0);
        send_touch(12'h800);
    endtask

    // Random touches, mostly from a small set of hot slices so that hits and
    // reordering happen often, with one limit in each of two phases.
    task automatic test_random_traffic(input int idle, input int stall,
                                       input logic [MAX_KEPT_W-1:0] limit_a,
                                       input logic [MAX_KEPT_W-1:0] limit_b);
        t_slice s;
        settle();
        idle_pct  = idle;
        stall_pct = stall;
        for (int h = 0; h < 2; h++) begin
            settle();
            write_limit(h == 0 ? limit_a : limit_b);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(99) < 70) begin
                    s = hot_slices[$urandom_range(19)];
                end else begin
                    s = t_slice'($urandom_range(4095));
                end
                send_touch(s);
            end
        end
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= '0;
        touch_if.valid        <= 1'b0;
        touch_if.slice_number <= '0;
        foreach (hot_slices[i]) begin
            hot_slices[i] = t_slice'($urandom_range(4095));
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_limit();
        test_limit_above_capacity();
        test_lowered_limit();
        test_random_traffic(0, 0, 5'd16, 5'd2);
        test_random_traffic(58, 0, 5'd1, 5'd31);
        test_random_traffic(0, 58, 5'd5, 5'd0);
        test_random_traffic(34, 34, MAX_KEPT_W'($urandom_range(31)),
                            MAX_KEPT_W'($urandom_range(31)));
        settle();

        if (evictions_due.size() != 0) begin
            $error("%0d predicted evictions never arrived", evictions_due.size());
            errors++;
        end
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ lru_slice_tracker.f @@
rtl/lst_pkg.sv
rtl/lst_touch_if.sv
rtl/lst_evict_if.sv
rtl/lst_datapath.sv
rtl/lst_controller.sv
rtl/lru_slice_tracker.sv
tb/sv/tb.sv
